@@ rtl/core/mlgs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlgs_pkg
// Shared types and constants for the multiplexed LED grayscale row scanner.
// ----------------------------------------------------------------------------
package mlgs_pkg;

  localparam int ROW_COUNT     = 9;
  localparam int BYTES_PER_ROW = 24;
  localparam int TOP_CHANNEL   = 15;
  localparam int STORE_DEPTH   = ROW_COUNT * BYTES_PER_ROW;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int ROW_W         = 4;
  localparam int CHAN_W        = 4;
  localparam int VALUE_W       = 12;
  localparam int IDX_W         = 5;
  localparam int COUNT_W       = 32;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic               action;
    logic [ROW_W-1:0]   row;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   lit_row;
    logic [ROW_W-1:0]   shift_row;
    logic [IDX_W-1:0]   byte_index;
    logic [7:0]         data_byte;
    logic [COUNT_W-1:0] update_count;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_FIRST,
    ST_WR_SECOND,
    ST_SCAN
  } ctrl_state_t;

  typedef struct packed {
    logic clr;
    logic load_write;
    logic scan_start;
    logic wr_first;
    logic wr_second;
    logic rd_issue;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic item_tick;
    logic item_row_ok;
    logic rd_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

@@ rtl/core/mlgs_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlgs_ctrl
// Sequencer: clears the frame store, runs the two-step channel write and
// issues the 24 byte reads of a scan tick.
// ----------------------------------------------------------------------------
module mlgs_ctrl
  import mlgs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (status.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          if (status.item_tick) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end else if (status.item_row_ok) begin
            cmd.load_write = 1'b1;
            state_next     = ST_WR_FIRST;
          end
        end
      end
      ST_WR_FIRST: begin
        cmd.wr_first = 1'b1;
        state_next   = ST_WR_SECOND;
      end
      ST_WR_SECOND: begin
        cmd.wr_second = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.out_free) begin
          cmd.rd_issue = 1'b1;
          if (status.rd_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/mlgs_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlgs_datapath
// Frame store as high and low nibble memories, row index, tick counter and
// the registered output word.
// ----------------------------------------------------------------------------
module mlgs_datapath
  import mlgs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire item_t   item,
  input  wire cmd_t    cmd,
  output status_t      status,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  logic [3:0] mem_hi [STORE_DEPTH];
  logic [3:0] mem_lo [STORE_DEPTH];

  logic [ADDR_W-1:0]  clr_addr;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_even;
  logic [VALUE_W-1:0] wr_value;
  logic [ROW_W-1:0]   cur_row;
  logic [ROW_W-1:0]   lit_row;
  logic [COUNT_W-1:0] tick_count;
  logic [ADDR_W-1:0]  rd_addr;
  logic [IDX_W-1:0]   rd_k;
  logic [3:0]         rd_hi;
  logic [3:0]         rd_lo;
  logic               out_valid;
  logic [ROW_W-1:0]   out_lit;
  logic [ROW_W-1:0]   out_shift;
  logic [IDX_W-1:0]   out_idx;
  logic [COUNT_W-1:0] out_count;
  logic               out_last;

  logic [CHAN_W-1:0]  pos;
  logic [5:0]         pos3;
  logic [ADDR_W-1:0]  item_addr;
  logic [ROW_W-1:0]   row_next;
  logic               we_hi;
  logic               we_lo;
  logic [ADDR_W-1:0]  waddr;
  logic [3:0]         wdata_hi;
  logic [3:0]         wdata_lo;

  assign pos       = CHAN_W'(TOP_CHANNEL) - item.channel;
  assign pos3      = {1'b0, pos, 1'b0} + {2'b00, pos};
  assign item_addr = ADDR_W'(item.row) * ADDR_W'(BYTES_PER_ROW) + ADDR_W'(pos3[5:1]);
  assign row_next  = (cur_row == ROW_W'(ROW_COUNT - 1)) ? '0 : cur_row + 1'b1;

  always_comb begin
    we_hi    = 1'b0;
    we_lo    = 1'b0;
    waddr    = wr_addr;
    wdata_hi = '0;
    wdata_lo = '0;
    if (cmd.clr) begin
      we_hi = 1'b1;
      we_lo = 1'b1;
      waddr = clr_addr;
    end else if (cmd.wr_first) begin
      we_hi    = wr_even;
      we_lo    = 1'b1;
      wdata_hi = wr_value[11:8];
      wdata_lo = wr_even ? wr_value[7:4] : wr_value[11:8];
    end else if (cmd.wr_second) begin
      we_hi    = 1'b1;
      we_lo    = !wr_even;
      waddr    = wr_addr + 1'b1;
      wdata_hi = wr_even ? wr_value[3:0] : wr_value[7:4];
      wdata_lo = wr_value[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we_hi) begin
      mem_hi[waddr] <= wdata_hi;
    end
    if (we_lo) begin
      mem_lo[waddr] <= wdata_lo;
    end
    if (cmd.rd_issue) begin
      rd_hi <= mem_hi[rd_addr];
      rd_lo <= mem_lo[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      cur_row    <= ROW_W'(ROW_COUNT - 1);
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.scan_start) begin
        cur_row    <= row_next;
        tick_count <= tick_count + 1'b1;
      end
      if (status.out_free) begin
        out_valid <= cmd.rd_issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_write) begin
      wr_addr  <= item_addr;
      wr_even  <= !pos[0];
      wr_value <= item.value;
    end
    if (cmd.scan_start) begin
      lit_row <= cur_row;
      rd_addr <= ADDR_W'(row_next) * ADDR_W'(BYTES_PER_ROW);
      rd_k    <= '0;
    end else if (cmd.rd_issue) begin
      rd_addr <= rd_addr + 1'b1;
      rd_k    <= rd_k + 1'b1;
    end
    if (cmd.rd_issue) begin
      out_lit   <= lit_row;
      out_shift <= cur_row;
      out_idx   <= rd_k;
      out_count <= tick_count;
      out_last  <= (rd_k == IDX_W'(BYTES_PER_ROW - 1));
    end
  end

  always_comb begin
    status.clr_done    = (clr_addr == ADDR_W'(STORE_DEPTH - 1));
    status.item_tick   = (item.action == ACT_TICK);
    status.item_row_ok = ({1'b0, item.row} < (ROW_W + 1)'(ROW_COUNT));
    status.rd_last     = (rd_k == IDX_W'(BYTES_PER_ROW - 1));
    status.out_free    = !out_valid || !result_stall;
  end

  assign result_valid        = out_valid;
  assign result.lit_row      = out_lit;
  assign result.shift_row    = out_shift;
  assign result.byte_index   = out_idx;
  assign result.data_byte    = {rd_hi, rd_lo};
  assign result.update_count = out_count;
  assign result.last         = out_last;

endmodule
`default_nettype wire

@@ rtl/core/multiplexed_led_grayscale_scan_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multiplexed_led_grayscale_scan_top
// Grayscale frame store and row scanner for a multiplexed LED matrix.
//
//   channel  direction  word      handshake
//   item     in         item_t    item_valid / item_stall
//   result   out        result_t  result_valid / result_stall
//
// A channel write is accepted, then done in two nibble-merge write steps.
// A tick is accepted, then one stored byte is read a cycle, while the result
// is not stalled, over the single read port of the frame store; 24 words out.
// After reset the frame store is cleared to zero with item_stall high.
// A stalled result holds the read pipeline.
// ----------------------------------------------------------------------------
module multiplexed_led_grayscale_scan_top
  import mlgs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  cmd_t    cmd;
  status_t status;

  mlgs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mlgs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire
